// ===== src/tlr_pkg.sv =====
// Shared types and constants for the thick line rasterizer.
// No dependencies; imported by every module of the block.
package tlr_pkg;

  localparam int unsigned CoordW     = 9;
  localparam int unsigned WinW       = 16;
  localparam int unsigned SizeW      = 8;
  localparam int unsigned ColorW     = 16;
  localparam int unsigned PanelShort = 240;
  localparam int unsigned PanelLong  = 320;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 104;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ORIENT_NONE  = 2'd0,
    ORIENT_ROT1  = 2'd1,
    ORIENT_ROT2  = 2'd2,
    ORIENT_ROT3  = 2'd3
  } orient_e;

  typedef struct packed {
    logic [ColorW-1:0] pen_color;
    logic [SizeW-1:0]  brush_size;
    logic [CoordW-1:0] end_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] start_x;
  } line_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  size;
    logic [ColorW-1:0] color;
    logic              last;
  } point_t;

  typedef struct packed {
    logic [WinW-1:0] y_last;
    logic [WinW-1:0] y_first;
    logic [WinW-1:0] x_last;
    logic [WinW-1:0] x_first;
  } window_t;

endpackage

// ===== src/tlr_step.sv =====
// Line state and one Bresenham step per item.
// Depends on tlr_pkg.
module tlr_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tlr_pkg::op_e       op_i,
  input  tlr_pkg::line_cmd_t cmd_i,
  output tlr_pkg::point_t    point_o
);
  import tlr_pkg::*;

  logic [CoordW-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic [CoordW:0]   dx_q, ndy_q;
  logic [1:0]        dirs_q;
  logic [11:0]       err_q;
  logic [SizeW-1:0]  size_q;
  logic [ColorW-1:0] color_q;
  logic              active_q;

  logic              start;
  logic [CoordW:0]   ld_dx, ld_dy, ld_ndy;
  logic [1:0]        ld_dirs;
  logic [11:0]       ld_err;

  logic [CoordW-1:0] cx, cy, tx, ty;
  logic [CoordW:0]   dx, ndy;
  logic [1:0]        dirs;
  logic [11:0]       err;
  logic [SizeW-1:0]  size;
  logic [ColorW-1:0] color;
  logic              active;

  logic signed [12:0] e2, ndy13, dx13;
  logic               xge, yle, xdone, xmove, ydone, ymove, done;
  logic [11:0]        err_d;
  logic [CoordW-1:0]  cur_x_d, cur_y_d;

  always_comb begin
    start   = (op_i == OP_START);
    ld_dx   = (cmd_i.end_x > cmd_i.start_x) ? {1'b0, cmd_i.end_x - cmd_i.start_x}
                                            : {1'b0, cmd_i.start_x - cmd_i.end_x};
    ld_dy   = (cmd_i.end_y > cmd_i.start_y) ? {1'b0, cmd_i.end_y - cmd_i.start_y}
                                            : {1'b0, cmd_i.start_y - cmd_i.end_y};
    ld_ndy  = (CoordW+1)'(0) - ld_dy;
    ld_dirs = {(cmd_i.start_y >= cmd_i.end_y), (cmd_i.start_x >= cmd_i.end_x)};
    ld_err  = {2'b00, ld_dx} + {{2{ld_ndy[CoordW]}}, ld_ndy};

    cx     = start ? cmd_i.start_x    : cur_x_q;
    cy     = start ? cmd_i.start_y    : cur_y_q;
    tx     = start ? cmd_i.end_x      : tgt_x_q;
    ty     = start ? cmd_i.end_y      : tgt_y_q;
    dx     = start ? ld_dx            : dx_q;
    ndy    = start ? ld_ndy           : ndy_q;
    dirs   = start ? ld_dirs          : dirs_q;
    err    = start ? ld_err           : err_q;
    size   = start ? cmd_i.brush_size : size_q;
    color  = start ? cmd_i.pen_color  : color_q;
    active = start | active_q;

    e2    = $signed({err, 1'b0});
    ndy13 = $signed({{3{ndy[CoordW]}}, ndy});
    dx13  = $signed({3'b000, dx});
    xge   = (e2 >= ndy13);
    yle   = (e2 <= dx13);
    xdone = xge && (cx == tx);
    xmove = xge && !xdone;
    ydone = !xdone && yle && (cy == ty);
    ymove = !xdone && yle && !ydone;
    done  = xdone | ydone;

    err_d = err + (xmove ? {{2{ndy[CoordW]}}, ndy} : 12'd0)
                + (ymove ? {2'b00, dx} : 12'd0);
    cur_x_d = cx;
    if (xmove) begin
      cur_x_d = dirs[0] ? cx - CoordW'(1) : cx + CoordW'(1);
    end
    cur_y_d = cy;
    if (ymove) begin
      cur_y_d = dirs[1] ? cy - CoordW'(1) : cy + CoordW'(1);
    end

    point_o.valid = active;
    point_o.x     = cx;
    point_o.y     = cy;
    point_o.size  = size;
    point_o.color = color;
    point_o.last  = active & done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      ndy_q    <= '0;
      dirs_q   <= '0;
      err_q    <= '0;
      size_q   <= SizeW'(1);
      color_q  <= '0;
      active_q <= 1'b0;
    end else if (fire_i && active) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tx;
      tgt_y_q  <= ty;
      dx_q     <= dx;
      ndy_q    <= ndy;
      dirs_q   <= dirs;
      err_q    <= err_d;
      size_q   <= size;
      color_q  <= color;
      active_q <= !done;
    end
  end

endmodule

// ===== src/tlr_remap.sv =====
// Brush square to panel window, remapped for the screen orientation.
// Depends on tlr_pkg; all window math wraps modulo 2^16.
module tlr_remap (
  input  tlr_pkg::orient_e        orient_i,
  input  tlr_pkg::point_t         point_i,
  output tlr_pkg::window_t        win_o
);
  import tlr_pkg::*;

  localparam logic [WinW-1:0] ShortM1 = WinW'(PanelShort - 1);
  localparam logic [WinW-1:0] LongM1  = WinW'(PanelLong - 1);

  logic [WinW-1:0] x0, y0, x1, y1;

  always_comb begin
    x0 = WinW'(point_i.x);
    y0 = WinW'(point_i.y);
    x1 = x0 + WinW'(point_i.size) - WinW'(1);
    y1 = y0 + WinW'(point_i.size) - WinW'(1);
    case (orient_i)
      ORIENT_ROT1: begin
        win_o.x_first = y0;
        win_o.x_last  = y1;
        win_o.y_first = LongM1 - x1;
        win_o.y_last  = LongM1 - x0;
      end
      ORIENT_ROT2: begin
        win_o.x_first = ShortM1 - x1;
        win_o.x_last  = ShortM1 - x0;
        win_o.y_first = LongM1 - y1;
        win_o.y_last  = LongM1 - y0;
      end
      ORIENT_ROT3: begin
        win_o.x_first = ShortM1 - y1;
        win_o.x_last  = ShortM1 - y0;
        win_o.y_first = x0;
        win_o.y_last  = x1;
      end
      default: begin
        win_o.x_first = x0;
        win_o.x_last  = x1;
        win_o.y_first = y0;
        win_o.y_last  = y1;
      end
    endcase
  end

endmodule

// ===== src/thick_line_rasterizer_top.sv =====
// Thick line rasterizer top: stream ports, input and result registers.
// Depends on tlr_pkg, tlr_step and tlr_remap.
// An accepted input passes through the input register, then the result register.
// Throughput: 1 item per cycle unless m_axis_tready stalls the result register;
// each item's step and window remap are combinational between the input and result registers.
// Reset (async, active low): no line active, orientation 0, brush size 1.
module thick_line_rasterizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,    // orientation
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x, start_y, end_x, end_y, brush_size, pen_color, 4'b0
  input  logic [tlr_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_x, point_y, win_x_first, win_x_last, win_y_first, win_y_last,
  // fill_color, 6'b0
  output logic [tlr_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,  // point_valid
  output logic                          m_axis_tlast   // last_point
);
  import tlr_pkg::*;

  orient_e   orient_q;
  logic      in_valid_q;
  op_e       in_op_q;
  line_cmd_t in_cmd_q;
  logic      out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic      out_user_q, out_last_q;

  logic      out_free, fire;
  point_t    point;
  window_t   win;
  logic [OutDataW-1:0] out_data_d;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= ORIENT_NONE;
    end else if (cfg_valid_i) begin
      orient_q <= orient_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= op_e'(s_axis_tuser);
      in_cmd_q <= line_cmd_t'(s_axis_tdata[$bits(line_cmd_t)-1:0]);
    end
  end

  tlr_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .op_i    (in_op_q),
    .cmd_i   (in_cmd_q),
    .point_o (point)
  );

  tlr_remap u_remap (
    .orient_i (orient_q),
    .point_i  (point),
    .win_o    (win)
  );

  always_comb begin
    out_data_d = '0;
    if (point.valid) begin
      out_data_d = OutDataW'({point.color, win.y_last, win.y_first,
                              win.x_last, win.x_first, point.y, point.x});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
      out_user_q <= point.valid;
      out_last_q <= point.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule
